@@ src/ilx_pkg.sv @@
// Shared types and constants for the integer literal lexer.
// Holds the beat structs, the classified character record and the character codes.
// No dependencies.
`timescale 1ns / 1ps

package ilx_pkg;

  // Character count ceiling: the smaller of the length limit and the 8-bit field range.
  localparam int unsigned LENGTH_LIMIT = 255;
  localparam logic [7:0]  COUNT_MAX    = (LENGTH_LIMIT < 255) ? 8'(LENGTH_LIMIT) : 8'd255;

  // Character codes used by the classifier.
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [7:0] CH_UB    = 8'h42;  // 'B'
  localparam logic [7:0] CH_LB    = 8'h62;  // 'b'
  localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
  localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
  localparam logic [7:0] CH_UU    = 8'h55;  // 'U'
  localparam logic [7:0] CH_LU    = 8'h75;  // 'u'
  localparam logic [7:0] CH_UL    = 8'h4C;  // 'L'
  localparam logic [7:0] CH_LL    = 8'h6C;  // 'l'
  localparam logic [7:0] CH_UE    = 8'h45;  // 'E'
  localparam logic [7:0] CH_LE    = 8'h65;  // 'e'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MANY_LONG = 2'd1;
  localparam logic [1:0] ST_MANY_UNS  = 2'd2;
  localparam logic [1:0] ST_REAL      = 2'd3;

  // Type code bases for signed and unsigned literals.
  localparam logic [2:0] TC_INT      = 3'd0;
  localparam logic [2:0] TC_UNSIGNED = 3'd3;

  // Queue depth between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  type_code;
    logic [1:0]  status;
    logic [7:0]  length;
    logic        too_long;
  } out_item_t;

  // One character after classification.
  typedef struct packed {
    logic       start;
    logic       is_zero;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] digit;
    logic       is_dot;
    logic       is_u;
    logic       is_l;
    logic       is_b;
    logic       is_x;
    logic       is_rext;
  } cls_t;

endpackage

@@ src/ilx_front.sv @@
// Front part of the integer literal lexer: classifies one input character.
// Produces the record that travels through the queue to the back part.
// Depends on ilx_pkg.
`timescale 1ns / 1ps

module ilx_front (
  input  ilx_pkg::in_item_t in_item,
  output ilx_pkg::cls_t     cls
);

  logic [7:0] c;
  logic       dec;
  logic       up_hex;
  logic       lo_hex;

  assign c = in_item.ch;

  // Digit ranges.
  assign dec    = (c >= ilx_pkg::CH_ZERO) && (c <= ilx_pkg::CH_NINE);
  assign up_hex = (c >= ilx_pkg::CH_UA) && (c <= ilx_pkg::CH_UF);
  assign lo_hex = (c >= ilx_pkg::CH_LA) && (c <= ilx_pkg::CH_LF);

  // Letters a-f and A-F share a low nibble of 1..6, so adding nine gives 10..15.
  always_comb begin
    cls.start   = in_item.start_req;
    cls.is_zero = (c == ilx_pkg::CH_ZERO);
    cls.is_dec  = dec;
    cls.is_hex  = dec || up_hex || lo_hex;
    cls.digit   = dec ? c[3:0] : 4'(c[3:0] + 4'd9);
    cls.is_dot  = (c == ilx_pkg::CH_DOT);
    cls.is_u    = (c == ilx_pkg::CH_LU) || (c == ilx_pkg::CH_UU);
    cls.is_l    = (c == ilx_pkg::CH_LL) || (c == ilx_pkg::CH_UL);
    cls.is_b    = (c == ilx_pkg::CH_LB) || (c == ilx_pkg::CH_UB);
    cls.is_x    = (c == ilx_pkg::CH_LX) || (c == ilx_pkg::CH_UX);
    cls.is_rext = (c == ilx_pkg::CH_LE) || (c == ilx_pkg::CH_UE) ||
                  (c == ilx_pkg::CH_LF) || (c == ilx_pkg::CH_UF);
  end

endmodule

@@ src/ilx_queue.sv @@
// Short queue of classified characters between the front and back parts.
// Registered entries with one read place at the head.
// Depends on ilx_pkg.
`timescale 1ns / 1ps

module ilx_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ilx_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output ilx_pkg::cls_t head
);

  ilx_pkg::cls_t                    q_mem_r [ilx_pkg::QUEUE_DEPTH];
  logic [ilx_pkg::QUEUE_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ilx_pkg::QUEUE_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ilx_pkg::QUEUE_AW:0]       count_r, count_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign full      = (count_r == (ilx_pkg::QUEUE_AW+1)'(ilx_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = q_mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer and count updates.
  always_comb begin
    wr_ptr_nxt = do_push ? ilx_pkg::QUEUE_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ilx_pkg::QUEUE_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = (ilx_pkg::QUEUE_AW+1)'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = (ilx_pkg::QUEUE_AW+1)'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/ilx_back.sv @@
// Back part of the integer literal lexer: literal state machine, value
// accumulation and the result output register.
// Depends on ilx_pkg.
`timescale 1ns / 1ps

module ilx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  ilx_pkg::cls_t      head,
  output logic               head_pop,
  input  logic [7:0]         max_len,
  output logic               out_valid,
  input  logic               out_ready,
  output ilx_pkg::out_item_t out_data
);

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_ZERO   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_SUFFIX = 5'b01000,
    PH_REAL   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    RX_BIN = 2'd0,
    RX_OCT = 2'd1,
    RX_DEC = 2'd2,
    RX_HEX = 2'd3
  } radix_t;

  phase_t      phase_r, phase_nxt;
  radix_t      radix_r, radix_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic [1:0]  long_cnt_r, long_cnt_nxt;
  logic [1:0]  uns_cnt_r, uns_cnt_nxt;
  logic [7:0]  char_cnt_r, char_cnt_nxt;
  logic        real_r, real_nxt;

  logic               out_valid_r;
  ilx_pkg::out_item_t out_data_r;
  ilx_pkg::out_item_t result;

  radix_t      eff_radix;
  logic [63:0] scaled;
  logic [63:0] mac;
  logic [7:0]  cnt_inc;
  logic [1:0]  long_inc;
  logic [1:0]  uns_inc;
  logic        is_sfx;
  logic        emit;
  logic        out_free;

  // A leading zero that is not a prefix makes the literal octal.
  assign eff_radix = (phase_r == PH_ZERO) ? RX_OCT : radix_r;

  // Constant-radix multiply as shifts; decimal is 8x plus 2x.
  always_comb begin
    case (eff_radix)
      RX_BIN:  scaled = {accum_r[62:0], 1'b0};
      RX_OCT:  scaled = {accum_r[60:0], 3'b0};
      RX_DEC:  scaled = 64'({accum_r[60:0], 3'b0} + {accum_r[62:0], 1'b0});
      RX_HEX:  scaled = {accum_r[59:0], 4'b0};
      default: scaled = accum_r;
    endcase
  end

  assign mac      = 64'(scaled + {60'b0, head.digit});
  assign cnt_inc  = (char_cnt_r < ilx_pkg::COUNT_MAX) ? 8'(char_cnt_r + 1'b1) : char_cnt_r;
  assign long_inc = (long_cnt_r != 2'd3) ? 2'(long_cnt_r + 1'b1) : long_cnt_r;
  assign uns_inc  = (uns_cnt_r != 2'd3) ? 2'(uns_cnt_r + 1'b1) : uns_cnt_r;
  assign is_sfx   = head.is_u || head.is_l;

  // Next literal state for the character at the queue head.
  always_comb begin
    phase_nxt    = phase_r;
    radix_nxt    = radix_r;
    accum_nxt    = accum_r;
    long_cnt_nxt = long_cnt_r;
    uns_cnt_nxt  = uns_cnt_r;
    char_cnt_nxt = char_cnt_r;
    real_nxt     = real_r;
    emit         = 1'b0;

    if (head.start) begin
      // A start mark closes any open literal and begins from a clean state.
      emit         = (phase_r != PH_IDLE);
      phase_nxt    = PH_IDLE;
      radix_nxt    = RX_DEC;
      accum_nxt    = '0;
      long_cnt_nxt = '0;
      uns_cnt_nxt  = '0;
      char_cnt_nxt = '0;
      real_nxt     = 1'b0;
      if (head.is_zero) begin
        phase_nxt    = PH_ZERO;
        char_cnt_nxt = 8'd1;
      end else if (head.is_hex) begin
        phase_nxt    = PH_DIGITS;
        accum_nxt    = {60'b0, head.digit};
        char_cnt_nxt = 8'd1;
      end else if (head.is_dot) begin
        phase_nxt    = PH_REAL;
        real_nxt     = 1'b1;
        char_cnt_nxt = 8'd1;
      end else if (is_sfx) begin
        phase_nxt    = PH_SUFFIX;
        uns_cnt_nxt  = head.is_u ? 2'd1 : 2'd0;
        long_cnt_nxt = head.is_l ? 2'd1 : 2'd0;
        char_cnt_nxt = 8'd1;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          emit = 1'b0;
        end
        PH_ZERO, PH_DIGITS: begin
          if ((phase_r == PH_ZERO) && head.is_b) begin
            radix_nxt    = RX_BIN;
            phase_nxt    = PH_DIGITS;
            char_cnt_nxt = cnt_inc;
          end else if ((phase_r == PH_ZERO) && head.is_x) begin
            radix_nxt    = RX_HEX;
            phase_nxt    = PH_DIGITS;
            char_cnt_nxt = cnt_inc;
          end else if (head.is_hex) begin
            radix_nxt    = eff_radix;
            phase_nxt    = PH_DIGITS;
            accum_nxt    = mac;
            char_cnt_nxt = cnt_inc;
          end else if (head.is_dot) begin
            radix_nxt    = eff_radix;
            phase_nxt    = PH_REAL;
            real_nxt     = 1'b1;
            char_cnt_nxt = cnt_inc;
          end else if (is_sfx) begin
            radix_nxt    = eff_radix;
            phase_nxt    = PH_SUFFIX;
            uns_cnt_nxt  = head.is_u ? uns_inc : uns_cnt_r;
            long_cnt_nxt = head.is_l ? long_inc : long_cnt_r;
            char_cnt_nxt = cnt_inc;
          end else begin
            emit = 1'b1;
          end
        end
        PH_SUFFIX: begin
          if (is_sfx) begin
            uns_cnt_nxt  = head.is_u ? uns_inc : uns_cnt_r;
            long_cnt_nxt = head.is_l ? long_inc : long_cnt_r;
            char_cnt_nxt = cnt_inc;
          end else begin
            emit = 1'b1;
          end
        end
        PH_REAL: begin
          if (head.is_dec || head.is_dot || head.is_rext) begin
            char_cnt_nxt = cnt_inc;
          end else begin
            emit = 1'b1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase

      // A terminating character closes the literal and is dropped.
      if (emit) begin
        phase_nxt    = PH_IDLE;
        radix_nxt    = RX_DEC;
        accum_nxt    = '0;
        long_cnt_nxt = '0;
        uns_cnt_nxt  = '0;
        char_cnt_nxt = '0;
        real_nxt     = 1'b0;
      end
    end
  end

  // Result of the literal held in the current state.
  always_comb begin
    result.value     = real_r ? 64'd0 : accum_r;
    result.type_code = ilx_pkg::TC_INT;
    result.length    = char_cnt_r;
    result.too_long  = (max_len != 8'd0) && (char_cnt_r > max_len);
    if (real_r) begin
      result.status = ilx_pkg::ST_REAL;
    end else if (long_cnt_r > 2'd2) begin
      result.status = ilx_pkg::ST_MANY_LONG;
    end else if (uns_cnt_r > 2'd1) begin
      result.status = ilx_pkg::ST_MANY_UNS;
    end else begin
      result.status    = ilx_pkg::ST_OK;
      result.type_code = 3'((uns_cnt_r != 2'd0) ? ilx_pkg::TC_UNSIGNED : ilx_pkg::TC_INT)
                         + {1'b0, long_cnt_r};
    end
  end

  // A character that emits waits only while the output register is occupied and not taken.
  assign out_free = !out_valid_r || out_ready;
  assign head_pop = head_valid && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      radix_r    <= RX_DEC;
      accum_r    <= '0;
      long_cnt_r <= '0;
      uns_cnt_r  <= '0;
      char_cnt_r <= '0;
      real_r     <= 1'b0;
    end else if (head_pop) begin
      phase_r    <= phase_nxt;
      radix_r    <= radix_nxt;
      accum_r    <= accum_nxt;
      long_cnt_r <= long_cnt_nxt;
      uns_cnt_r  <= uns_cnt_nxt;
      char_cnt_r <= char_cnt_nxt;
      real_r     <= real_nxt;
    end
  end

  // Output register: loads a result beat, clears when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (head_pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop && emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/integer_literal_lexer.sv @@
// Top level of the integer literal lexer: configuration register, front
// classifier, queue and back state machine.
// Depends on ilx_pkg, ilx_front, ilx_queue and ilx_back.
//
//   Channel  Direction  Handshake             Beat
//   in_      input      in_valid / in_ready   in_data  (ch, start_req)
//   out_     output     out_valid / out_ready out_data (value, type_code, status,
//                                                       length, too_long)
//   cfg_     input      cfg_we                cfg_wdata (max_literal_length)
//
// One character beat per cycle is taken and processed while the queue has room
// and no emitting character waits on a stalled output; the back part does one
// shift-add step of the value per cycle, which sets that rate.
// A taken beat is registered in the queue; a result is loaded into the output
// register when its terminating beat leaves the queue.
// Reset is synchronous and active low; it clears the literal state, the queue
// and the threshold register. A stalled output holds back only characters that
// would emit; the four-entry queue keeps in_ready high until it fills.
`timescale 1ns / 1ps

module integer_literal_lexer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ilx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ilx_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  logic [7:0]    max_len_r;
  ilx_pkg::cls_t cls;
  ilx_pkg::cls_t head;
  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;

  // Length warning threshold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 8'd0;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  assign in_ready = !q_full;

  ilx_front u_front (
    .in_item (in_data),
    .cls     (cls)
  );

  ilx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  ilx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_not_empty),
    .head       (head),
    .head_pop   (q_pop),
    .max_len    (max_len_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

@@ test/tb_integer_literal_lexer.sv @@
// Self-checking testbench for integer_literal_lexer: directed literals, then random literal
// streams under several length thresholds, checked beat by beat against an in-bench predictor.
// Depends on ilx_pkg and the integer_literal_lexer RTL.
`timescale 1ns / 1ps

module tb_integer_literal_lexer;

  typedef enum logic [4:0] {
    LX_IDLE   = 5'b00001,
    LX_ZERO   = 5'b00010,
    LX_DIGITS = 5'b00100,
    LX_SUFFIX = 5'b01000,
    LX_REAL   = 5'b10000
  } lex_phase_t;
  typedef enum logic [1:0] {RAD_BIN, RAD_OCT, RAD_DEC, RAD_HEX} radix_t;

  localparam int          PHASE_ITEMS   = 300;
  localparam int          SETTLE_CYCLES = 20;
  localparam logic [7:0]  CH_SPACE      = 8'h20;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  ilx_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ilx_pkg::out_item_t out_data;
  logic               cfg_we    = 1'b0;
  logic [7:0]         cfg_wdata = '0;

  integer_literal_lexer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Stimulus and scoreboard storage.
  ilx_pkg::in_item_t  char_queue[$];
  ilx_pkg::out_item_t expected_literals[$];
  int                 items_pushed = 0;
  int                 items_taken  = 0;
  int                 error_count  = 0;
  logic               in_accepted  = 1'b0;

  // Predictor copy of the lexer state and the threshold register.
  lex_phase_t  lex_phase     = LX_IDLE;
  radix_t      lex_radix     = RAD_DEC;
  logic [63:0] lex_value     = '0;
  logic [1:0]  lex_longs     = '0;
  logic [1:0]  lex_unsigneds = '0;
  logic [7:0]  lex_count     = '0;
  logic        lex_real      = 1'b0;
  logic [7:0]  max_len       = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #4_000_000;
    $display("tb_integer_literal_lexer: errors");
    $finish;
  end

  // Digit value of a character, or -1 when it is not a hex digit.
  function automatic int digit_of(logic [7:0] c);
    if (c >= ilx_pkg::CH_ZERO && c <= ilx_pkg::CH_NINE) return int'(c - ilx_pkg::CH_ZERO);
    if (c >= ilx_pkg::CH_UA && c <= ilx_pkg::CH_UF) return int'(c - ilx_pkg::CH_UA) + 10;
    if (c >= ilx_pkg::CH_LA && c <= ilx_pkg::CH_LF) return int'(c - ilx_pkg::CH_LA) + 10;
    return -1;
  endfunction

  function automatic bit is_suffix_char(logic [7:0] c);
    return c == ilx_pkg::CH_LU || c == ilx_pkg::CH_UU ||
           c == ilx_pkg::CH_LL || c == ilx_pkg::CH_UL;
  endfunction

  function automatic logic [63:0] radix_factor(radix_t rad);
    case (rad)
      RAD_BIN: return 64'd2;
      RAD_OCT: return 64'd8;
      RAD_DEC: return 64'd10;
      default: return 64'd16;
    endcase
  endfunction

  function automatic void bump_count();
    if (lex_count < ilx_pkg::COUNT_MAX) lex_count++;
  endfunction

  function automatic void bump_suffix(logic [7:0] c);
    if (c == ilx_pkg::CH_LU || c == ilx_pkg::CH_UU) begin
      if (lex_unsigneds != 2'd3) lex_unsigneds++;
    end else begin
      if (lex_longs != 2'd3) lex_longs++;
    end
  endfunction

  function automatic void clear_literal();
    lex_phase     = LX_IDLE;
    lex_radix     = RAD_DEC;
    lex_value     = '0;
    lex_longs     = '0;
    lex_unsigneds = '0;
    lex_count     = '0;
    lex_real      = 1'b0;
  endfunction

  // Feeds one character to the open literal; returns 1 when it ends the literal.
  function automatic bit feed_char(logic [7:0] c);
    int d;
    d = digit_of(c);
    if (lex_phase == LX_ZERO) begin
      if (c == ilx_pkg::CH_LB || c == ilx_pkg::CH_UB) begin
        lex_radix = RAD_BIN;
        lex_phase = LX_DIGITS;
        bump_count();
        return 1'b0;
      end
      if (c == ilx_pkg::CH_LX || c == ilx_pkg::CH_UX) begin
        lex_radix = RAD_HEX;
        lex_phase = LX_DIGITS;
        bump_count();
        return 1'b0;
      end
      lex_radix = RAD_OCT;
      lex_phase = LX_DIGITS;
    end
    case (lex_phase)
      LX_DIGITS: begin
        if (d >= 0) begin
          lex_value = lex_value * radix_factor(lex_radix) + 64'(d);
          bump_count();
          return 1'b0;
        end
        if (c == ilx_pkg::CH_DOT) begin
          lex_real  = 1'b1;
          lex_phase = LX_REAL;
          bump_count();
          return 1'b0;
        end
        if (is_suffix_char(c)) begin
          lex_phase = LX_SUFFIX;
          bump_suffix(c);
          bump_count();
          return 1'b0;
        end
        return 1'b1;
      end
      LX_SUFFIX: begin
        if (is_suffix_char(c)) begin
          bump_suffix(c);
          bump_count();
          return 1'b0;
        end
        return 1'b1;
      end
      LX_REAL: begin
        if ((c >= ilx_pkg::CH_ZERO && c <= ilx_pkg::CH_NINE) || c == ilx_pkg::CH_DOT ||
            c == ilx_pkg::CH_LE || c == ilx_pkg::CH_UE ||
            c == ilx_pkg::CH_LF || c == ilx_pkg::CH_UF) begin
          bump_count();
          return 1'b0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Result of the literal held in the predictor state.
  function automatic ilx_pkg::out_item_t literal_result();
    ilx_pkg::out_item_t r;
    r = '0;
    if (lex_real) r.status = ilx_pkg::ST_REAL;
    else if (lex_longs > 2'd2) r.status = ilx_pkg::ST_MANY_LONG;
    else if (lex_unsigneds > 2'd1) r.status = ilx_pkg::ST_MANY_UNS;
    else r.type_code = ((lex_unsigneds != 2'd0) ? ilx_pkg::TC_UNSIGNED : ilx_pkg::TC_INT) +
                       3'(lex_longs);
    r.value    = lex_real ? 64'd0 : lex_value;
    r.length   = lex_count;
    r.too_long = (max_len != 8'd0) && (lex_count > max_len);
    return r;
  endfunction

  // Advances the predictor by one character beat; returns 1 when a literal is emitted.
  function automatic bit predict_literal(input ilx_pkg::in_item_t it,
                                         output ilx_pkg::out_item_t r);
    bit emitted;
    emitted = 1'b0;
    r = '0;
    if (it.start_req) begin
      if (lex_phase != LX_IDLE) begin
        r = literal_result();
        emitted = 1'b1;
      end
      clear_literal();
      if (it.ch == ilx_pkg::CH_ZERO) begin
        lex_phase = LX_ZERO;
        bump_count();
      end else if (digit_of(it.ch) >= 0 || it.ch == ilx_pkg::CH_DOT ||
                   is_suffix_char(it.ch)) begin
        lex_phase = LX_DIGITS;
        void'(feed_char(it.ch));
      end
      return emitted;
    end
    if (lex_phase == LX_IDLE) return 1'b0;
    if (feed_char(it.ch)) begin
      r = literal_result();
      clear_literal();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Short gaps are common, long ones rare.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Random digit for a radix, with an occasional digit from the full hex set.
  function automatic logic [7:0] rand_digit(radix_t rad);
    string hex_chars = "0123456789abcdefABCDEF";
    if ($urandom_range(0, 9) == 0) return hex_chars[$urandom_range(0, 21)];
    case (rad)
      RAD_BIN: return ilx_pkg::CH_ZERO + 8'($urandom_range(0, 1));
      RAD_OCT: return ilx_pkg::CH_ZERO + 8'($urandom_range(0, 7));
      RAD_DEC: return ilx_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      default: return hex_chars[$urandom_range(0, 21)];
    endcase
  endfunction

  task automatic push_char(logic [7:0] c, logic st);
    char_queue.push_back('{ch: c, start_req: st});
    items_pushed++;
  endtask

  // First character carries the start mark.
  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0);
  endtask

  // One random literal followed by an optional random tail of terminators and noise.
  task automatic gen_literal(input bit huge);
    string term_chars = " ;,)+\n";
    string suffix_chars = "uUlL";
    string odd_chars = ".uUlL0";
    string hex_chars = "0123456789abcdefABCDEF";
    int kind;
    int ndig;
    int nsuf;
    int tail;
    radix_t rad;
    logic [7:0] body[$];
    kind = $urandom_range(0, 9);
    if (huge) ndig = $urandom_range(250, 300);
    else if ($urandom_range(0, 3) == 0) ndig = $urandom_range(13, 30);
    else ndig = $urandom_range(0, 8);
    rad = RAD_DEC;
    case (kind)
      3: begin
        body.push_back(ilx_pkg::CH_ZERO);
        rad = RAD_OCT;
      end
      4, 5: begin
        body.push_back(ilx_pkg::CH_ZERO);
        body.push_back($urandom_range(0, 1) ? ilx_pkg::CH_LX : ilx_pkg::CH_UX);
        rad = RAD_HEX;
      end
      6: begin
        body.push_back(ilx_pkg::CH_ZERO);
        body.push_back($urandom_range(0, 1) ? ilx_pkg::CH_LB : ilx_pkg::CH_UB);
        rad = RAD_BIN;
      end
      7: ;
      8: begin
        body.push_back(odd_chars[$urandom_range(0, odd_chars.len() - 1)]);
        ndig = ndig % 3;
      end
      default: begin
        if ($urandom_range(0, 9) == 0) body.push_back(hex_chars[$urandom_range(10, 21)]);
        else body.push_back(ilx_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
      end
    endcase
    repeat (ndig) body.push_back(rand_digit(rad));
    if (kind == 7) begin
      // Real literal: mantissa, optional exponent, optional float suffix.
      body.push_back(ilx_pkg::CH_DOT);
      repeat ($urandom_range(0, 4)) body.push_back(rand_digit(RAD_DEC));
      if ($urandom_range(0, 1)) begin
        body.push_back($urandom_range(0, 1) ? ilx_pkg::CH_LE : ilx_pkg::CH_UE);
        repeat ($urandom_range(0, 3)) body.push_back(rand_digit(RAD_DEC));
      end
      if ($urandom_range(0, 2) == 0) begin
        body.push_back($urandom_range(0, 1) ? ilx_pkg::CH_LF : ilx_pkg::CH_UF);
      end
    end else begin
      tail = $urandom_range(0, 9);
      if (tail < 4) nsuf = 0;
      else if (tail < 9) nsuf = $urandom_range(1, 2);
      else nsuf = $urandom_range(3, 4);
      repeat (nsuf) body.push_back(suffix_chars[$urandom_range(0, 3)]);
    end
    foreach (body[i]) push_char(body[i], i == 0);
    tail = $urandom_range(0, 99);
    if (tail < 85 && tail >= 60) return;
    if ($urandom_range(0, 3) == 0) push_char(8'($urandom_range(0, 255)), 1'b0);
    else push_char(term_chars[$urandom_range(0, term_chars.len() - 1)], 1'b0);
    if (tail >= 85) begin
      repeat ($urandom_range(1, 4))
        push_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end
  endtask

  // Waits until every beat is taken and every literal has come back, then lets the pipe settle.
  task automatic drain();
    do @(negedge clk);
    while (items_taken != items_pushed || expected_literals.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input driver: presents queued beats with random gaps and occasional gap-free runs.
  int in_gap  = 0;
  int in_calm = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (char_queue.size() != 0) begin
        in_data  <= char_queue.pop_front();
        in_valid <= 1'b1;
        if (in_calm > 0) begin
          in_calm--;
        end else begin
          if ($urandom_range(0, 63) == 0) in_calm = $urandom_range(30, 120);
          in_gap = idle_span();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  int out_stall = 0;
  int out_calm  = 0;
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
      if (out_calm > 0) begin
        out_calm--;
      end else begin
        if ($urandom_range(0, 63) == 0) out_calm = $urandom_range(30, 120);
        out_stall = idle_span();
      end
    end
  end

  // Monitor: checks result beats, then predicts from the accepted character beat.
  always @(posedge clk) begin
    ilx_pkg::out_item_t want;
    ilx_pkg::out_item_t made;
    in_accepted <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_literals.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          error_count++;
        end else begin
          want = expected_literals.pop_front();
          check_field("value", want.value, out_data.value);
          check_field("type_code", 64'(want.type_code), 64'(out_data.type_code));
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("length", 64'(want.length), 64'(out_data.length));
          check_field("too_long", 64'(want.too_long), 64'(out_data.too_long));
        end
      end
      if (in_valid && in_ready) begin
        items_taken++;
        if (predict_literal(in_data, made)) expected_literals.push_back(made);
      end
    end
  end

  // Main sequence: reset, directed literals, then random phases under several thresholds.
  initial begin
    logic [7:0] thresholds[5];
    int mark;
    thresholds = '{8'd255, 8'd1, 8'd12, 8'd0, 8'd0};
    thresholds[3] = 8'($urandom_range(2, 254));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the threshold at its reset value.
    push_char(CH_SPACE, 1'b0);          // idle without a start: ignored
    push_text("0x1F;");
    push_text("0XffULL ");
    push_text("0b101");
    push_text("0B2,");                  // start while a literal is open
    push_text("017lu");
    push_text("09a ");
    push_text("0 ");
    push_text("0x)");
    push_text("123uL5");                // digit after a suffix ends the literal
    push_text("1lll;");
    push_text("7uU;");
    push_text("2UUlll;");               // too many l wins over too many u
    push_text("1.5e3Fx");
    push_text(".E.f;");
    push_text("u ");
    push_text("x1");                    // start on a non-literal character is dropped
    push_text("abcdef ");
    push_text("0xFFFFFFFFFFFFFFFFF ");  // wraps past 64 bits
    push_text("0x.9 ");
    push_char(8'hFF, 1'b1);
    push_text("4");
    push_char(8'h80, 1'b0);
    drain();

    foreach (thresholds[p]) begin
      cfg_we    <= 1'b1;
      cfg_wdata <= thresholds[p];
      max_len    = thresholds[p];
      @(negedge clk);
      cfg_we    <= 1'b0;
      mark = items_pushed;
      gen_literal(1'b1);
      while (items_pushed - mark < PHASE_ITEMS) gen_literal(1'b0);
      push_char(CH_SPACE, 1'b0);
      drain();
    end

    if (error_count == 0) begin
      $display("tb_integer_literal_lexer: clean");
    end else begin
      $display("tb_integer_literal_lexer: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ilx_pkg.sv
src/ilx_front.sv
src/ilx_queue.sv
src/ilx_back.sv
src/integer_literal_lexer.sv
test/tb_integer_literal_lexer.sv
